FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define TSLT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TSLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TSLT_ASSERT_SAME(label, clk, rst, ante, cons)
`define TSLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/tslt_pkg.sv
// Package for the thread slot lifecycle table: widths, codes and command structs.
// Used by every module of the block; no dependencies.
`default_nettype none

package tslt_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int LIMIT_W    = 6;
   localparam int EFF_W      = (SLOT_CNT_W > LIMIT_W) ? SLOT_CNT_W : LIMIT_W;
   localparam int BASE_W     = 18;
   localparam int NUMBER_W   = 19;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(32);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = CSR_IDX_W'(1);

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      PH_FREE = 2'd0,
      PH_BUSY = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      K_ALLOC   = 2'd0,
      K_QUERY   = 2'd1,
      K_TERM    = 2'd2,
      K_RELEASE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_PHASE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic         clear;
      logic         we;
      slot_idx_type idx;
      phase_type    phase;
   } phase_cmd_type;

   typedef struct packed {
      logic         alloc_we;
      logic         exit_we;
      logic         rd_en;
      slot_idx_type idx;
   } store_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/thread_slot_lifecycle_table.sv
// Thread slot lifecycle table: request sequencer, config registers, response register.
// Depends on tslt_pkg, tslt_phase_table, tslt_slot_store and assert_macros.svh.
//
// Usage:
//   req_* carries one request word (allocate, query, terminate, release); it is
//   taken when req_valid is high and req_stall is low. Every request gives exactly
//   one response word on rsp_*, taken when rsp_valid is high and rsp_stall low.
//   csr_we writes slot_limit (index 0, clears every slot to free) or base_number
//   (index 1); other indexes are ignored. Write only while the block is idle.
// Timing:
//   A request is taken in the idle state, executed against the phase table and
//   payload memories in the next cycle, and its response loaded in the emit state
//   after the memory read, once the response register is free; the registered
//   rsp_valid rises after that load. One request is in flight at a time: a new one
//   is taken only after the response of the last one has been loaded.
// Reset:
//   Synchronous, active high. All slots free, slot_limit 32, base_number 0.
// Stall:
//   The response register holds a word while rsp_stall is high; the next request
//   is still taken and executed, and waits to load until the register frees up.
`default_nettype none
`include "assert_macros.svh"

module thread_slot_lifecycle_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [tslt_pkg::NUMBER_W-1:0]       req_thread_number,
   input  logic [tslt_pkg::WORD_W-1:0]         req_control_block,
   input  logic [tslt_pkg::WORD_W-1:0]         req_stack_base,
   input  logic [tslt_pkg::WORD_W-1:0]         req_stack_length,
   input  logic signed [tslt_pkg::WORD_W-1:0]  req_exit_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [tslt_pkg::NUMBER_W-1:0]       rsp_granted_number,
   output logic [1:0]                          rsp_slot_status,
   output logic [tslt_pkg::WORD_W-1:0]         rsp_control_block_out,
   output logic [tslt_pkg::WORD_W-1:0]         rsp_stack_base_out,
   output logic [tslt_pkg::WORD_W-1:0]         rsp_stack_length_out,
   output logic signed [tslt_pkg::WORD_W-1:0]  rsp_exit_code_out,
   input  logic                                csr_we,
   input  logic [tslt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tslt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tslt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0] limit_ff;
   logic [BASE_W-1:0]  base_ff;

   kind_type            kind_ff;
   logic [NUMBER_W-1:0] number_ff;
   logic [WORD_W-1:0]   cb_ff, sb_ff, sl_ff, exit_ff;

   status_type          pend_status_ff, pend_status_in;
   logic [NUMBER_W-1:0] pend_granted_ff, pend_granted_in;
   logic [1:0]          pend_slot_ff, pend_slot_in;
   logic                pend_release_ff, pend_release_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [NUMBER_W-1:0] rsp_granted_ff;
   logic [1:0]          rsp_slot_ff;
   logic [WORD_W-1:0]   rsp_cb_ff, rsp_sb_ff, rsp_sl_ff;
   logic signed [WORD_W-1:0] rsp_exit_ff;

   logic                req_take;
   logic                rsp_load;
   logic [EFF_W-1:0]    lim_ext;
   logic [EFF_W-1:0]    eff_limit;
   logic [NUMBER_W:0]   diff;
   logic                in_range;
   slot_idx_type        loc_idx;
   logic                rsp_data_zero;

   phase_cmd_type       phase_cmd;
   store_cmd_type       store_cmd;
   phase_type           rd_phase;
   logic                free_found;
   slot_idx_type        free_idx;
   logic [WORD_W-1:0]   rd_cb, rd_sb, rd_sl, rd_exit;

   tslt_phase_table u_phase (
      .clock      (clock),
      .reset      (reset),
      .cmd        (phase_cmd),
      .rd_idx     (loc_idx),
      .eff_limit  (eff_limit),
      .rd_phase   (rd_phase),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   tslt_slot_store u_store (
      .clock            (clock),
      .cmd              (store_cmd),
      .control_block    (cb_ff),
      .stack_base       (sb_ff),
      .stack_length     (sl_ff),
      .exit_code        (exit_ff),
      .rd_control_block (rd_cb),
      .rd_stack_base    (rd_sb),
      .rd_stack_length  (rd_sl),
      .rd_exit_code     (rd_exit)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         base_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_LIMIT) begin
            limit_ff <= csr_wdata[LIMIT_W-1:0];
         end
         if (csr_index == CSR_BASE) begin
            base_ff <= csr_wdata[BASE_W-1:0];
         end
      end
   end

   assign lim_ext   = EFF_W'(limit_ff);
   assign eff_limit = (lim_ext > EFF_W'(SLOT_COUNT)) ? EFF_W'(SLOT_COUNT) : lim_ext;

   assign diff     = {1'b0, number_ff} - (NUMBER_W + 1)'(base_ff);
   assign in_range = !diff[NUMBER_W] && (diff[NUMBER_W-1:0] < NUMBER_W'(eff_limit));
   assign loc_idx  = diff[SLOT_IDX_W-1:0];

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff   <= kind_type'(req_kind);
         number_ff <= req_thread_number;
         cb_ff     <= req_control_block;
         sb_ff     <= req_stack_base;
         sl_ff     <= req_stack_length;
         exit_ff   <= req_exit_code;
      end
   end

   // execute: decide, update phase, write or read payload
   always_comb begin
      phase_cmd       = '0;
      phase_cmd.clear = csr_we && (csr_index == CSR_LIMIT);
      phase_cmd.idx   = loc_idx;
      phase_cmd.phase = PH_FREE;
      store_cmd       = '0;
      store_cmd.idx   = loc_idx;
      pend_status_in  = pend_status_ff;
      pend_granted_in = pend_granted_ff;
      pend_slot_in    = pend_slot_ff;
      pend_release_in = pend_release_ff;
      if (state_ff == S_EXEC) begin
         pend_status_in  = ST_OK;
         pend_granted_in = '0;
         pend_slot_in    = '0;
         pend_release_in = 1'b0;
         if (kind_ff == K_ALLOC) begin
            if (free_found) begin
               phase_cmd.we       = 1'b1;
               phase_cmd.idx      = free_idx;
               phase_cmd.phase    = PH_BUSY;
               store_cmd.alloc_we = 1'b1;
               store_cmd.idx      = free_idx;
               pend_granted_in    = NUMBER_W'(base_ff) + NUMBER_W'(free_idx);
            end else begin
               pend_status_in = ST_FULL;
            end
         end else if (!in_range) begin
            pend_status_in = ST_RANGE;
         end else begin
            case (kind_ff)
               K_QUERY: begin
                  pend_slot_in = rd_phase;
               end
               K_TERM: begin
                  if (rd_phase == PH_BUSY) begin
                     phase_cmd.we      = 1'b1;
                     phase_cmd.phase   = PH_DONE;
                     store_cmd.exit_we = 1'b1;
                  end else begin
                     pend_status_in = ST_PHASE;
                  end
               end
               default: begin
                  if (rd_phase == PH_DONE) begin
                     phase_cmd.we    = 1'b1;
                     phase_cmd.phase = PH_FREE;
                     store_cmd.rd_en = 1'b1;
                     pend_release_in = 1'b1;
                  end else begin
                     pend_status_in = ST_PHASE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff  <= pend_status_in;
      pend_granted_ff <= pend_granted_in;
      pend_slot_ff    <= pend_slot_in;
      pend_release_ff <= pend_release_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // response register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= pend_status_ff;
         rsp_granted_ff <= pend_granted_ff;
         rsp_slot_ff    <= pend_slot_ff;
         rsp_cb_ff      <= pend_release_ff ? rd_cb : '0;
         rsp_sb_ff      <= pend_release_ff ? rd_sb : '0;
         rsp_sl_ff      <= pend_release_ff ? rd_sl : '0;
         rsp_exit_ff    <= pend_release_ff ? rd_exit : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_granted_number    = rsp_granted_ff;
   assign rsp_slot_status       = rsp_slot_ff;
   assign rsp_control_block_out = rsp_cb_ff;
   assign rsp_stack_base_out    = rsp_sb_ff;
   assign rsp_stack_length_out  = rsp_sl_ff;
   assign rsp_exit_code_out     = rsp_exit_ff;

   assign rsp_data_zero = (rsp_granted_number == '0) && (rsp_control_block_out == '0) &&
                          (rsp_exit_code_out == '0);

   `TSLT_ASSERT_NEXT(a_take_to_exec, clock, reset, req_take, state_ff == S_EXEC)
   `TSLT_ASSERT_NEXT(a_exec_to_emit, clock, reset, state_ff == S_EXEC, state_ff == S_EMIT)
   `TSLT_ASSERT_SAME(a_fail_no_data, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_data_zero)

endmodule

`default_nettype wire

FILE: rtl/tslt_phase_table.sv
// Per-slot phase flops with bulk clear, one indexed read and lowest-free search.
// Depends on tslt_pkg.
`default_nettype none

module tslt_phase_table (
   input  logic                        clock,
   input  logic                        reset,
   input  tslt_pkg::phase_cmd_type     cmd,
   input  tslt_pkg::slot_idx_type      rd_idx,
   input  logic [tslt_pkg::EFF_W-1:0]  eff_limit,
   output tslt_pkg::phase_type         rd_phase,
   output logic                        free_found,
   output tslt_pkg::slot_idx_type      free_idx
);
   import tslt_pkg::*;

   phase_type phase_ff [SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            phase_ff[i] <= PH_FREE;
         end
      end else if (cmd.we) begin
         phase_ff[cmd.idx] <= cmd.phase;
      end
   end

   assign rd_phase = phase_ff[rd_idx];

   // lowest free slot below the active limit
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_FREE && EFF_W'(i) < eff_limit) begin
            free_found = 1'b1;
            free_idx   = SLOT_IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tslt_slot_store.sv
// Slot payload memories: allocate words and exit codes, registered read port.
// Depends on tslt_pkg.
`default_nettype none

module tslt_slot_store (
   input  logic                          clock,
   input  tslt_pkg::store_cmd_type       cmd,
   input  logic [tslt_pkg::WORD_W-1:0]   control_block,
   input  logic [tslt_pkg::WORD_W-1:0]   stack_base,
   input  logic [tslt_pkg::WORD_W-1:0]   stack_length,
   input  logic [tslt_pkg::WORD_W-1:0]   exit_code,
   output logic [tslt_pkg::WORD_W-1:0]   rd_control_block,
   output logic [tslt_pkg::WORD_W-1:0]   rd_stack_base,
   output logic [tslt_pkg::WORD_W-1:0]   rd_stack_length,
   output logic [tslt_pkg::WORD_W-1:0]   rd_exit_code
);
   import tslt_pkg::*;

   logic [3*WORD_W-1:0] alloc_mem [SLOT_COUNT];
   logic [WORD_W-1:0]   exit_mem  [SLOT_COUNT];
   logic [3*WORD_W-1:0] rd_alloc_ff;
   logic [WORD_W-1:0]   rd_exit_ff;

   always_ff @(posedge clock) begin
      if (cmd.alloc_we) begin
         alloc_mem[cmd.idx] <= {control_block, stack_base, stack_length};
      end
      if (cmd.rd_en) begin
         rd_alloc_ff <= alloc_mem[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exit_we) begin
         exit_mem[cmd.idx] <= exit_code;
      end
      if (cmd.rd_en) begin
         rd_exit_ff <= exit_mem[cmd.idx];
      end
   end

   assign rd_control_block = rd_alloc_ff[3*WORD_W-1:2*WORD_W];
   assign rd_stack_base    = rd_alloc_ff[2*WORD_W-1:WORD_W];
   assign rd_stack_length  = rd_alloc_ff[WORD_W-1:0];
   assign rd_exit_code     = rd_exit_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for thread_slot_lifecycle_table: directed and random request words
// against a behavioral slot table, with random sender gaps and receiver stalls.
// Depends on tslt_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb_top;
   import tslt_pkg::*;

   localparam int NUMBER_TOP = 262175;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);
   localparam logic [NUMBER_W-1:0] HIGH_BASE = NUMBER_W'(262143);

   typedef struct packed {
      kind_type              kind;
      logic [NUMBER_W-1:0]   number;
      logic [WORD_W-1:0]     control_block;
      logic [WORD_W-1:0]     stack_base;
      logic [WORD_W-1:0]     stack_length;
      logic [WORD_W-1:0]     exit_code;
   } slot_request_type;

   typedef struct packed {
      status_type            status;
      logic [NUMBER_W-1:0]   granted_number;
      logic [1:0]            slot_status;
      logic [WORD_W-1:0]     control_block;
      logic [WORD_W-1:0]     stack_base;
      logic [WORD_W-1:0]     stack_length;
      logic [WORD_W-1:0]     exit_code;
   } slot_reply_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [1:0]                  req_kind;
   logic [NUMBER_W-1:0]         req_thread_number;
   logic [WORD_W-1:0]           req_control_block;
   logic [WORD_W-1:0]           req_stack_base;
   logic [WORD_W-1:0]           req_stack_length;
   logic signed [WORD_W-1:0]    req_exit_code;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [1:0]                  rsp_status;
   logic [NUMBER_W-1:0]         rsp_granted_number;
   logic [1:0]                  rsp_slot_status;
   logic [WORD_W-1:0]           rsp_control_block_out;
   logic [WORD_W-1:0]           rsp_stack_base_out;
   logic [WORD_W-1:0]           rsp_stack_length_out;
   logic signed [WORD_W-1:0]    rsp_exit_code_out;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   // slot table as the block should hold it
   logic [LIMIT_W-1:0]          mirror_limit;
   logic [BASE_W-1:0]           mirror_base;
   phase_type                   mirror_phase [SLOT_COUNT];
   logic [WORD_W-1:0]           mirror_cb [SLOT_COUNT];
   logic [WORD_W-1:0]           mirror_sb [SLOT_COUNT];
   logic [WORD_W-1:0]           mirror_sl [SLOT_COUNT];
   logic [WORD_W-1:0]           mirror_ec [SLOT_COUNT];

   slot_request_type            requests_waiting [$];
   slot_reply_type              replies_due [$];
   slot_request_type            line_item;
   bit                          word_on_line = 1'b0;
   int                          send_idle_pct = 0;
   int                          stall_pct = 0;
   int                          mismatches = 0;

   thread_slot_lifecycle_table u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_thread_number     (req_thread_number),
      .req_control_block     (req_control_block),
      .req_stack_base        (req_stack_base),
      .req_stack_length      (req_stack_length),
      .req_exit_code         (req_exit_code),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_granted_number    (rsp_granted_number),
      .rsp_slot_status       (rsp_slot_status),
      .rsp_control_block_out (rsp_control_block_out),
      .rsp_stack_base_out    (rsp_stack_base_out),
      .rsp_stack_length_out  (rsp_stack_length_out),
      .rsp_exit_code_out     (rsp_exit_code_out),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_slots();
      return (int'(mirror_limit) > SLOT_COUNT) ? SLOT_COUNT : int'(mirror_limit);
   endfunction

   function automatic slot_reply_type serve_request(slot_request_type r);
      slot_reply_type rep;
      int eff, idx, i;
      bit found;
      rep = '0;
      rep.status = ST_OK;
      eff = active_slots();
      idx = int'(r.number) - int'(mirror_base);
      found = 1'b0;
      if (r.kind == K_ALLOC) begin
         rep.status = ST_FULL;
         for (i = 0; i < eff; i++) begin
            if (!found && mirror_phase[i] == PH_FREE) begin
               found = 1'b1;
               mirror_phase[i] = PH_BUSY;
               mirror_cb[i] = r.control_block;
               mirror_sb[i] = r.stack_base;
               mirror_sl[i] = r.stack_length;
               rep.status = ST_OK;
               rep.granted_number = NUMBER_W'(int'(mirror_base) + i);
            end
         end
      end else if (idx < 0 || idx >= eff) begin
         rep.status = ST_RANGE;
      end else begin
         case (r.kind)
            K_QUERY: begin
               rep.slot_status = mirror_phase[idx];
            end
            K_TERM: begin
               if (mirror_phase[idx] != PH_BUSY) begin
                  rep.status = ST_PHASE;
               end else begin
                  mirror_ec[idx] = r.exit_code;
                  mirror_phase[idx] = PH_DONE;
               end
            end
            default: begin
               if (mirror_phase[idx] != PH_DONE) begin
                  rep.status = ST_PHASE;
               end else begin
                  rep.control_block = mirror_cb[idx];
                  rep.stack_base = mirror_sb[idx];
                  rep.stack_length = mirror_sl[idx];
                  rep.exit_code = mirror_ec[idx];
                  mirror_phase[idx] = PH_FREE;
               end
            end
         endcase
      end
      return rep;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   // request side: acceptance and prediction at the rising edge, driving at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         replies_due = {replies_due, serve_request(line_item)};
         word_on_line = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (!word_on_line) begin
         if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            line_item = requests_waiting.pop_front();
            word_on_line = 1'b1;
            req_valid <= 1'b1;
            req_kind <= line_item.kind;
            req_thread_number <= line_item.number;
            req_control_block <= line_item.control_block;
            req_stack_base <= line_item.stack_base;
            req_stack_length <= line_item.stack_length;
            req_exit_code <= line_item.exit_code;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // response side
   always @(posedge clock) begin : check_reply
      slot_reply_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("response word with none expected");
            mismatches++;
         end else begin
            due = replies_due.pop_front();
            check_field("status", WORD_W'(due.status), WORD_W'(rsp_status));
            check_field("granted_number", WORD_W'(due.granted_number),
                        WORD_W'(rsp_granted_number));
            check_field("slot_status", WORD_W'(due.slot_status), WORD_W'(rsp_slot_status));
            check_field("control_block_out", due.control_block, rsp_control_block_out);
            check_field("stack_base_out", due.stack_base, rsp_stack_base_out);
            check_field("stack_length_out", due.stack_length, rsp_stack_length_out);
            check_field("exit_code_out", due.exit_code, rsp_exit_code_out);
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LIMIT) begin
         mirror_limit = data[LIMIT_W-1:0];
         foreach (mirror_phase[i]) mirror_phase[i] = PH_FREE;
      end else if (idx == CSR_BASE) begin
         mirror_base = data[BASE_W-1:0];
      end
   endtask

   task automatic queue_request(input kind_type kind, input logic [NUMBER_W-1:0] number,
                                input logic [WORD_W-1:0] cb, input logic [WORD_W-1:0] sb,
                                input logic [WORD_W-1:0] sl, input logic [WORD_W-1:0] ec);
      slot_request_type r;
      r.kind = kind;
      r.number = number;
      r.control_block = cb;
      r.stack_base = sb;
      r.stack_length = sl;
      r.exit_code = ec;
      requests_waiting = {requests_waiting, r};
   endtask

   // mostly well-formed lifecycle traffic aimed at slots in the right phase, some noise
   task automatic add_random_request();
      int eff, pick, n, i;
      int busy_slots [$];
      int done_slots [$];
      kind_type kind;
      eff = active_slots();
      for (i = 0; i < eff; i++) begin
         if (mirror_phase[i] == PH_BUSY) busy_slots = {busy_slots, i};
         if (mirror_phase[i] == PH_DONE) done_slots = {done_slots, i};
      end
      n = int'(mirror_base) + int'($urandom_range(eff + 1)) - 1;
      pick = $urandom_range(99);
      if (pick < 32) begin
         kind = K_ALLOC;
         n = $urandom_range(NUMBER_TOP);
      end else if (pick < 57) begin
         kind = K_TERM;
         if (busy_slots.size() != 0 && $urandom_range(9) < 8)
            n = int'(mirror_base) + busy_slots[$urandom_range(busy_slots.size() - 1)];
      end else if (pick < 82) begin
         kind = K_RELEASE;
         if (done_slots.size() != 0 && $urandom_range(9) < 8)
            n = int'(mirror_base) + done_slots[$urandom_range(done_slots.size() - 1)];
      end else if (pick < 94) begin
         kind = K_QUERY;
      end else begin
         kind = kind_type'($urandom_range(3));
         n = $urandom_range(NUMBER_TOP);
      end
      if (n < 0) n = 0;
      if (n > NUMBER_TOP) n = NUMBER_TOP;
      queue_request(kind, NUMBER_W'(n), rand_word(), rand_word(), rand_word(), rand_word());
   endtask

   task automatic settle();
      @(posedge clock);
      while (requests_waiting.size() != 0 || word_on_line || replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 79; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 79; end
         default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
   endtask

   initial begin : stimulus
      int p, count, lim, n;
      logic [BASE_W-1:0] bas;
      logic [CSR_DATA_W-1:0] limit_word;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = K_ALLOC;
      req_thread_number = '0;
      req_control_block = '0;
      req_stack_base = '0;
      req_stack_length = '0;
      req_exit_code = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_LIMIT;
      csr_wdata = '0;
      mirror_limit = LIMIT_RESET;
      mirror_base = '0;
      foreach (mirror_phase[i]) begin
         mirror_phase[i] = PH_FREE;
         mirror_cb[i] = '0;
         mirror_sb[i] = '0;
         mirror_sl[i] = '0;
         mirror_ec[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // directed: two slots at the highest base value
      write_csr(CSR_BASE, '1);
      write_csr(CSR_LIMIT, CSR_DATA_W'(2));
      write_csr(CSR_SPARE_B, '1);
      write_csr(CSR_SPARE_A, CSR_DATA_W'(18'h15555));
      queue_request(K_QUERY, HIGH_BASE, '0, '0, '0, '0);
      queue_request(K_TERM, HIGH_BASE, '0, '0, '0, '1);
      queue_request(K_RELEASE, HIGH_BASE, '0, '0, '0, '0);
      queue_request(K_ALLOC, NUMBER_W'(NUMBER_TOP), '1, '0, '1, '0);
      queue_request(K_ALLOC, '0, '0, '1, '0, '1);
      queue_request(K_ALLOC, HIGH_BASE, 32'h1234_5678, 32'h9abc_def0, 32'h0000_1000, '0);
      queue_request(K_QUERY, HIGH_BASE + NUMBER_W'(1), '0, '0, '0, '0);
      queue_request(K_RELEASE, HIGH_BASE + NUMBER_W'(1), '0, '0, '0, '0);
      queue_request(K_TERM, HIGH_BASE + NUMBER_W'(1), '0, '0, '0, 32'h8000_0000);
      queue_request(K_TERM, HIGH_BASE + NUMBER_W'(1), '0, '0, '0, '0);
      queue_request(K_QUERY, HIGH_BASE + NUMBER_W'(1), '0, '0, '0, '0);
      queue_request(K_RELEASE, HIGH_BASE + NUMBER_W'(1), '0, '0, '0, '0);
      queue_request(K_TERM, HIGH_BASE, '1, '1, '1, 32'h7fff_ffff);
      queue_request(K_RELEASE, HIGH_BASE, '0, '0, '0, '0);
      queue_request(K_QUERY, HIGH_BASE - NUMBER_W'(1), '0, '0, '0, '0);
      queue_request(K_QUERY, HIGH_BASE + NUMBER_W'(2), '0, '0, '0, '0);
      queue_request(K_TERM, NUMBER_W'(NUMBER_TOP), '0, '0, '0, '1);
      queue_request(K_RELEASE, '0, '0, '0, '0, '0);
      queue_request(K_ALLOC, '0, 32'hcafe_0001, 32'h0000_8000, 32'h0000_0400, '0);
      settle();
      // limit write frees every slot
      write_csr(CSR_LIMIT, CSR_DATA_W'(1));
      queue_request(K_QUERY, HIGH_BASE, '0, '0, '0, '0);
      queue_request(K_ALLOC, '0, 32'h0bad_f00d, '1, '0, '0);
      settle();
      // base write keeps slot phases
      write_csr(CSR_BASE, '0);
      queue_request(K_QUERY, '0, '0, '0, '0, '0);
      queue_request(K_QUERY, NUMBER_W'(1), '0, '0, '0, '0);
      settle();

      for (p = 0; p < 8; p++) begin
         count = 185;
         bas = BASE_W'($urandom_range(262143));
         lim = 32;
         case (p)
            0: bas = '0;
            1: lim = 4;
            2: begin lim = 1; bas = '1; end
            3: begin lim = 63; bas = BASE_W'(7); end
            4: begin lim = 0; count = 60; end
            5: lim = $urandom_range(31, 2);
            6: begin lim = $urandom_range(62, 33); bas = '0; end
            default: begin lim = 8; bas = '1; end
         endcase
         limit_word = {CSR_DATA_W'($urandom) >> LIMIT_W << LIMIT_W} | CSR_DATA_W'(lim);
         if (p == 0) limit_word = CSR_DATA_W'(32);
         if (p == 3) limit_word = '1;
         if (p == 5) begin
            write_csr(CSR_SPARE_A, CSR_DATA_W'($urandom));
            write_csr(CSR_SPARE_B, '0);
         end
         write_csr(CSR_BASE, bas);
         write_csr(CSR_LIMIT, limit_word);
         set_idling(p % 4);
         for (n = 0; n < count; n++) begin
            while (requests_waiting.size() >= 2) @(posedge clock);
            add_random_request();
         end
         settle();
      end

      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
